// ----- rtl/rhc_pkg.sv -----
`default_nettype none

package rhc_pkg;

    localparam int CH_W  = 8;
    localparam int IN_W  = 3 * CH_W;
    localparam int Q_W   = 16;
    localparam int OUT_W = 2 * Q_W + CH_W;
    localparam int DEN_W = 11;
    localparam int REM_W = DEN_W;
    localparam int NUM_W = REM_W + Q_W;

    typedef struct packed {
        logic [NUM_W-1:0] hue_num;
        logic [DEN_W-1:0] hue_den;
        logic [NUM_W-1:0] sat_num;
        logic [DEN_W-1:0] sat_den;
        logic [CH_W-1:0]  bright;
    } div_req_t;

    typedef struct packed {
        logic [Q_W-1:0]  hue;
        logic [Q_W-1:0]  sat;
        logic [CH_W-1:0] bright;
    } div_rsp_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   low;
        logic [Q_W-1:0]   quot;
        logic [DEN_W-1:0] den;
    } div_lane_t;

    function automatic div_lane_t div_load(input logic [NUM_W-1:0] num,
                                           input logic [DEN_W-1:0] den);
        div_lane_t l;
        l.rem  = num[NUM_W-1:Q_W];
        l.low  = num[Q_W-1:0];
        l.quot = '0;
        l.den  = den;
        return l;
    endfunction

    // one restoring step: shift in the next numerator bit, subtract if it fits
    function automatic div_lane_t div_step(input div_lane_t a);
        div_lane_t      b;
        logic [REM_W:0] t;
        b = a;
        t = {a.rem, a.low[Q_W-1]};
        b.low = {a.low[Q_W-2:0], 1'b0};
        if (t >= {1'b0, a.den}) begin
            b.rem  = REM_W'(t - {1'b0, a.den});
            b.quot = {a.quot[Q_W-2:0], 1'b1};
        end else begin
            b.rem  = t[REM_W-1:0];
            b.quot = {a.quot[Q_W-2:0], 1'b0};
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rhc_div_pipe.sv -----
`default_nettype none

module rhc_div_pipe (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire rhc_pkg::div_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output rhc_pkg::div_rsp_t      rsp
);
    import rhc_pkg::*;

    logic [Q_W-1:0] valid_reg;
    logic [Q_W-1:0] valid_next;
    logic [Q_W-1:0] en;
    div_lane_t      hue_reg [Q_W];
    div_lane_t      hue_next [Q_W];
    div_lane_t      sat_reg [Q_W];
    div_lane_t      sat_next [Q_W];
    logic [CH_W-1:0] bright_reg [Q_W];
    logic [CH_W-1:0] bright_next [Q_W];

    // a stage loads when it is empty or its content moves on
    always_comb begin
        en[Q_W-1] = !valid_reg[Q_W-1] || rsp_ready;
        for (int k = Q_W - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb begin
        valid_next[0]  = req_valid;
        hue_next[0]    = div_step(div_load(req.hue_num, req.hue_den));
        sat_next[0]    = div_step(div_load(req.sat_num, req.sat_den));
        bright_next[0] = req.bright;
        for (int k = 1; k < Q_W; k++) begin
            valid_next[k]  = valid_reg[k-1];
            hue_next[k]    = div_step(hue_reg[k-1]);
            sat_next[k]    = div_step(sat_reg[k-1]);
            bright_next[k] = bright_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < Q_W; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < Q_W; k++) begin
            if (en[k]) begin
                hue_reg[k]    <= hue_next[k];
                sat_reg[k]    <= sat_next[k];
                bright_reg[k] <= bright_next[k];
            end
        end
    end

    assign req_ready = en[0];
    assign rsp_valid = valid_reg[Q_W-1];
    // packed as hue, sat, bright from the top bit down
    assign rsp       = {hue_reg[Q_W-1].quot, sat_reg[Q_W-1].quot, bright_reg[Q_W-1]};

    a_hue_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[Q_W-1] |-> ({1'b0, hue_reg[Q_W-1].rem} < {1'b0, hue_reg[Q_W-1].den}))
        else $error("hue remainder not below divisor");
    a_sat_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[Q_W-1] |-> ({1'b0, sat_reg[Q_W-1].rem} < {1'b0, sat_reg[Q_W-1].den}))
        else $error("saturation remainder not below divisor");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[Q_W-1] && !rsp_ready |=> valid_reg[Q_W-1] && $stable(rsp))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- rtl/rgb_to_hsv_converter_top.sv -----
`default_nettype none

// RGB to HSV conversion, one pixel per clock while m_tready is high. A pixel (red,
// green, blue) enters on the s_ stream and its hue, saturation and brightness
// leave on the m_ stream once through the pipeline: three front stages find max,
// min and the hue sector and form the two dividends, then two 16-stage restoring
// dividers run side by side, one quotient bit per stage. Every stage holds its
// own valid bit and fills empty slots during a stall, so s_tready stays high
// until the whole pipeline is full and one transfer per cycle is sustained.
// Hue is a fraction of a turn scaled by 65536, saturation is scaled by 65535,
// both rounded to nearest; grey and black pixels give zero hue and saturation.
module rgb_to_hsv_converter_top (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [rhc_pkg::IN_W-1:0]  s_tdata,   // red, green, blue
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [rhc_pkg::OUT_W-1:0] m_tdata    // hue, saturation, brightness
);
    import rhc_pkg::*;

    typedef enum logic [2:0] {
        SEC_RED   = 3'b001,
        SEC_GREEN = 3'b010,
        SEC_BLUE  = 3'b100
    } sector_t;

    logic            en0, en1, en2;
    logic            v0_reg, v1_reg, v2_reg;
    logic [CH_W-1:0] red0_reg, green0_reg, blue0_reg;

    logic [CH_W-1:0] hi1_next, lo1_next, delta1_next;
    logic [CH_W-1:0] hi1_reg, delta1_reg;
    logic signed [CH_W:0] diff1_next, diff1_reg;
    sector_t         sec1_next, sec1_reg;

    logic [CH_W+1:0] off_term;
    logic signed [CH_W+3:0] n_raw;
    logic signed [CH_W+3:0] n_wrap;
    logic [DEN_W-1:0] delta6;
    logic [CH_W+1:0]  delta3;
    div_req_t        req_next, req_reg;

    logic            div_ready;
    logic            rsp_valid;
    div_rsp_t        rsp;

    assign en2      = !v2_reg || div_ready;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign s_tready = en0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en0) begin
                v0_reg <= s_tvalid;
            end
            if (en1) begin
                v1_reg <= v0_reg;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en0) begin
            red0_reg   <= s_tdata[CH_W-1:0];
            green0_reg <= s_tdata[2*CH_W-1:CH_W];
            blue0_reg  <= s_tdata[3*CH_W-1:2*CH_W];
        end
    end

    // max, min and sector, ties go to red then green
    always_comb begin
        hi1_next = (red0_reg > green0_reg) ? red0_reg : green0_reg;
        if (blue0_reg > hi1_next) begin
            hi1_next = blue0_reg;
        end
        lo1_next = (red0_reg < green0_reg) ? red0_reg : green0_reg;
        if (blue0_reg < lo1_next) begin
            lo1_next = blue0_reg;
        end
        delta1_next = hi1_next - lo1_next;
        if (red0_reg == hi1_next) begin
            sec1_next  = SEC_RED;
            diff1_next = $signed({1'b0, green0_reg}) - $signed({1'b0, blue0_reg});
        end else if (green0_reg == hi1_next) begin
            sec1_next  = SEC_GREEN;
            diff1_next = $signed({1'b0, blue0_reg}) - $signed({1'b0, red0_reg});
        end else begin
            sec1_next  = SEC_BLUE;
            diff1_next = $signed({1'b0, red0_reg}) - $signed({1'b0, green0_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            hi1_reg    <= hi1_next;
            delta1_reg <= delta1_next;
            diff1_reg  <= diff1_next;
            sec1_reg   <= sec1_next;
        end
    end

    // sector offset, wrap into one turn, build dividends and divisors
    always_comb begin
        case (sec1_reg)
            SEC_RED:   off_term = '0;
            SEC_GREEN: off_term = {1'b0, delta1_reg, 1'b0};
            SEC_BLUE:  off_term = {delta1_reg, 2'b00};
            default:   off_term = '0;
        endcase
        delta6 = DEN_W'({delta1_reg, 2'b00}) + DEN_W'({delta1_reg, 1'b0});
        delta3 = {1'b0, delta1_reg, 1'b0} + {2'b00, delta1_reg};
        n_raw  = $signed({2'b00, off_term}) + (CH_W+4)'(diff1_reg);
        n_wrap = n_raw;
        if (n_raw < 0) begin
            n_wrap = n_raw + $signed({1'b0, delta6});
        end
        req_next.bright = hi1_reg;
        if (delta1_reg == '0) begin
            req_next.hue_num = '0;
            req_next.hue_den = DEN_W'(1);
            req_next.sat_num = '0;
            req_next.sat_den = DEN_W'(1);
        end else begin
            req_next.hue_num = {n_wrap[DEN_W-1:0], Q_W'(delta3)};
            req_next.hue_den = delta6;
            req_next.sat_num = NUM_W'({delta1_reg, 17'd0})
                             - NUM_W'({delta1_reg, 1'b0})
                             + NUM_W'(hi1_reg);
            req_next.sat_den = DEN_W'({hi1_reg, 1'b0});
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            req_reg <= req_next;
        end
    end

    rhc_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (v2_reg),
        .req_ready (div_ready),
        .req       (req_reg),
        .rsp_valid (rsp_valid),
        .rsp_ready (m_tready),
        .rsp       (rsp)
    );

    assign m_tvalid = rsp_valid;
    assign m_tdata  = {rsp.bright, rsp.sat, rsp.hue};

    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (req_reg.hue_den != '0) && (req_reg.sat_den != '0))
        else $error("zero divisor entered divider");
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> ({1'b0, req_reg.hue_num[NUM_W-1:Q_W]} < {1'b0, req_reg.hue_den}))
        else $error("hue quotient would overflow");
    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> ({1'b0, req_reg.sat_num[NUM_W-1:Q_W]} < {1'b0, req_reg.sat_den}))
        else $error("saturation quotient would overflow");
    a_black_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_valid && (rsp.bright == '0) |-> (rsp.hue == '0) && (rsp.sat == '0))
        else $error("black pixel with nonzero hue or saturation");

endmodule

`default_nettype wire

// ----- sim/rgb_to_hsv_converter_top_test.sv -----
`timescale 1ns / 100ps

module rgb_to_hsv_converter_top_test;

    localparam int RANDOM_PIXELS  = 1850;
    localparam int CALM_TAIL      = 250;
    localparam int HOLD_AFTER     = 500;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] sat;
        logic [7:0]  bright;
    } hsv_t;

    logic                       aclk     = 1'b0;
    logic                       aresetn  = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic [rhc_pkg::IN_W-1:0]   s_tdata  = '0;  // red, green, blue
    logic                       m_tready = 1'b0;
    wire                        s_tready;
    wire                        m_tvalid;
    wire  [rhc_pkg::OUT_W-1:0]  m_tdata;        // hue, saturation, brightness

    logic [rhc_pkg::IN_W-1:0] pending_pixels[$];
    hsv_t                     expected_hsv[$];

    int errors       = 0;
    int pixels_in    = 0;
    int results_out  = 0;
    int grey_pixels  = 0;
    int backpressure = 0;
    int send_gap     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int idle_cycles  = 0;

    rgb_to_hsv_converter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic hsv_t rgb_to_hsv(input logic [7:0] red, input logic [7:0] green,
                                        input logic [7:0] blue);
        int   r;
        int   g;
        int   b;
        int   hi;
        int   lo;
        int   delta;
        int   n;
        hsv_t res;
        r = int'(red);
        g = int'(green);
        b = int'(blue);
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        delta = hi - lo;
        res = '0;
        res.bright = 8'(hi);
        if (delta != 0) begin
            res.sat = 16'((2 * delta * 65535 + hi) / (2 * hi));
            if (r == hi)
                n = g - b;
            else if (g == hi)
                n = 2 * delta + b - r;
            else
                n = 4 * delta + r - g;
            if (n < 0)
                n += 6 * delta;
            res.hue = 16'((2 * n * 65536 + 6 * delta) / (12 * delta));
        end
        return res;
    endfunction

    initial begin
        forever #6 aclk = ~aclk;
    end

    // sender
    always @(posedge aclk) begin
        logic                     nv;
        logic [rhc_pkg::IN_W-1:0] nd;
        nv = s_tvalid;
        nd = s_tdata;
        if (!aresetn) begin
            nv = 1'b0;
        end else begin
            if (s_tvalid && !s_tready)
                backpressure++;
            if (s_tvalid && s_tready) begin
                expected_hsv.push_back(rgb_to_hsv(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]));
                pixels_in++;
                if (s_tdata[7:0] == s_tdata[15:8] && s_tdata[7:0] == s_tdata[23:16])
                    grey_pixels++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_pixels.size() > 0) begin
                    if (pending_pixels.size() > CALM_TAIL && hold_left == 0
                            && $urandom_range(0, 11) == 0) begin
                        send_gap = $urandom_range(1, 10) - 1;
                    end else begin
                        nd = pending_pixels.pop_front();
                        nv = 1'b1;
                    end
                end
            end
        end
        s_tvalid <= nv;
        s_tdata  <= nd;
    end

    // receiver and checker
    always @(posedge aclk) begin
        logic nr;
        hsv_t got;
        hsv_t want;
        nr = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.hue    = m_tdata[15:0];
                got.sat    = m_tdata[31:16];
                got.bright = m_tdata[39:32];
                if (expected_hsv.size() == 0) begin
                    $error("result transfer with no pixel outstanding");
                    errors++;
                end else begin
                    want = expected_hsv.pop_front();
                    results_out++;
                    if (got.hue !== want.hue) begin
                        $error("hue: expected %0d, actual %0d", want.hue, got.hue);
                        errors++;
                    end
                    if (got.sat !== want.sat) begin
                        $error("saturation: expected %0d, actual %0d", want.sat, got.sat);
                        errors++;
                    end
                    if (got.bright !== want.bright) begin
                        $error("brightness: expected %0d, actual %0d", want.bright, got.bright);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (!hold_done && pixels_in >= HOLD_AFTER) begin
                // long hold-off so the pipeline fills and stalls its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (pending_pixels.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
            end else begin
                nr = 1'b1;
            end
        end
        m_tready <= nr;
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no transfer for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    initial begin
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        int         kind;

        // pixels packed as {blue, green, red}
        pending_pixels.push_back({8'd0,   8'd0,   8'd0});
        pending_pixels.push_back({8'd255, 8'd255, 8'd255});
        pending_pixels.push_back({8'd128, 8'd128, 8'd128});
        pending_pixels.push_back({8'd1,   8'd1,   8'd1});
        pending_pixels.push_back({8'd0,   8'd0,   8'd255});
        pending_pixels.push_back({8'd0,   8'd255, 8'd0});
        pending_pixels.push_back({8'd255, 8'd0,   8'd0});
        pending_pixels.push_back({8'd0,   8'd255, 8'd255});
        pending_pixels.push_back({8'd255, 8'd255, 8'd0});
        pending_pixels.push_back({8'd255, 8'd0,   8'd255});
        pending_pixels.push_back({8'd1,   8'd0,   8'd255});
        pending_pixels.push_back({8'd0,   8'd1,   8'd255});
        pending_pixels.push_back({8'd0,   8'd0,   8'd1});
        pending_pixels.push_back({8'd0,   8'd1,   8'd0});
        pending_pixels.push_back({8'd1,   8'd0,   8'd0});
        pending_pixels.push_back({8'd1,   8'd0,   8'd1});
        pending_pixels.push_back({8'd254, 8'd254, 8'd255});
        pending_pixels.push_back({8'd255, 8'd255, 8'd254});
        pending_pixels.push_back({8'd0,   8'd1,   8'd2});
        pending_pixels.push_back({8'd1,   8'd2,   8'd0});
        pending_pixels.push_back({8'd2,   8'd0,   8'd1});
        pending_pixels.push_back({8'd0,   8'd128, 8'd255});
        pending_pixels.push_back({8'd255, 8'd170, 8'd85});
        pending_pixels.push_back({8'd1,   8'd255, 8'd0});

        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            kind = $urandom_range(0, 9);
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
            case (kind)
                0: begin
                    g = r;
                    b = r;
                end
                1: g = r;
                2: b = g;
                3: b = r;
                4: begin
                    r = 8'($urandom_range(0, 3));
                    g = 8'($urandom_range(0, 3));
                    b = 8'($urandom_range(0, 3));
                end
                default: ;
            endcase
            pending_pixels.push_back({b, g, r});
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_pixels.size() != 0 || s_tvalid || expected_hsv.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d pixels converted and checked (%0d grey or black), directed corners first",
                 results_out, grey_pixels);
        $display("random idling on both sides, one %0d-cycle output hold, input stalled %0d cycles",
                 HOLD_CYCLES, backpressure);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rhc_pkg.sv
rtl/rhc_div_pipe.sv
rtl/rgb_to_hsv_converter_top.sv
sim/rgb_to_hsv_converter_top_test.sv
